FILE: hw/rtl/iq4dq_pkg.sv
// iq4dq_pkg: shared types, codes and helpers of the 4-bit block dequantizer
// used by iq4dq_mul and nonlinear_4bit_block_dequantizer_core, no dependencies
package iq4dq_pkg;

  localparam int SuperblockValues = 256;
  localparam int SubblockValues   = 32;
  localparam int CntW             = 3;
  localparam int MulAW            = 17;
  localparam int MulBW            = 8;
  localparam int MulPW            = MulAW + MulBW;
  localparam int Half2SingleBias  = 112;
  localparam int HalfMantW        = 10;

  localparam logic OpHeader = 1'b0;
  localparam logic OpQuant  = 1'b1;

  localparam logic CfgLevelFirst  = 1'b0;
  localparam logic CfgLevelSecond = 1'b1;

  localparam logic [31:0] SingleInf  = 32'h7f80_0000;
  localparam logic [31:0] SingleQNan = 32'h7fc0_0000;
  localparam logic [31:0] QuietBit   = 32'h0040_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_HOLD,
    ST_VAL
  } state_e;

  // exact integer magnitude times 2^(e_eff-25) packed as single precision
  function automatic logic [31:0] to_single(logic sgn, logic [4:0] e_eff,
                                            logic [23:0] mag);
    logic [4:0]  p;
    logic [7:0]  ex;
    logic [23:0] sh;
    p = '0;
    for (int i = 0; i < 24; i++) begin
      if (mag[i]) p = 5'(i);
    end
    sh = mag << (5'd23 - p);
    ex = 8'(e_eff) + 8'(Half2SingleBias - HalfMantW) + 8'(p);
    if (mag == '0) return {sgn, 31'b0};
    return {sgn, ex, sh[22:0]};
  endfunction

endpackage

FILE: hw/rtl/iq4dq_mul.sv
// iq4dq_mul: shared unsigned multiplier with a registered product
// uses iq4dq_pkg for operand widths
module iq4dq_mul (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  logic [iq4dq_pkg::MulAW-1:0]   a_i,
  input  logic [iq4dq_pkg::MulBW-1:0]   b_i,
  output logic [iq4dq_pkg::MulPW-1:0]   prod_o
);

  logic [iq4dq_pkg::MulPW-1:0] prod_q, prod_d;

  // product of the two magnitudes
  assign prod_d = iq4dq_pkg::MulPW'(a_i) * iq4dq_pkg::MulPW'(b_i);

  always_ff @(posedge clk_i) begin
    if (load_i) prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

FILE: hw/rtl/nonlinear_4bit_block_dequantizer_core.sv
// nonlinear_4bit_block_dequantizer_core: top level of the 4-bit block dequantizer
// uses iq4dq_pkg and iq4dq_mul
//
// Usage: the input channel (in_valid_i / in_stall_o) takes one word per item.
// A header word (opcode 0) loads the half-precision block scale and the packed
// 6-bit sub-scales and restarts the sub-block count; it gives no output.
// A quant word (opcode 1) carries 16 bytes and yields 32 output words
// (value_o, position_o, last_o) on out_valid_o / out_stall_i: low nibbles of
// bytes 0-15 first, then the high nibbles, last_o set on position 31.
// Sequence: a header leaves the sequencer idle. A quant word first passes the
// scale setup (PREP, one pass through the shared multiplier), then per value
// a multiply step (HOLD) and a normalize/output step (VAL); the single shared
// multiplier serializes the values, and no new word is taken until the last
// value has gone to the output register. in_stall_o is high for the whole item.
// A stall on the output holds the output register and the sequencer waits in
// its normalize step. Reset clears the level tables, the held header and the
// sub-block count; a quant word before any header sees a scale of +0.
// Level tables are written through cfg_we_i / cfg_index_i / cfg_data_i; the
// user must do so only while idle, the block itself does not enforce it.
module nonlinear_4bit_block_dequantizer_core #(
  parameter int SUPERBLOCK_VALUES = iq4dq_pkg::SuperblockValues
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [15:0] block_scale_i,
  input  logic [15:0] subscale_high_bits_i,
  input  logic [31:0] subscale_low_nibbles_i,
  input  logic [63:0] quant_bytes_first_i,
  input  logic [63:0] quant_bytes_second_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] value_o,
  output logic [4:0]  position_o,
  output logic        last_o
);

  localparam int Subblocks = SUPERBLOCK_VALUES / iq4dq_pkg::SubblockValues;

  iq4dq_pkg::state_e state_q, state_d;

  logic [63:0] lvl_first_q, lvl_second_q;
  logic [15:0] scale_h_q;
  logic [15:0] sub_hi_q;
  logic [31:0] sub_lo_q;
  logic [iq4dq_pkg::CntW-1:0] cnt_q;
  logic [127:0] bytes_q;
  logic [5:0]  s_abs_q;
  logic        s_neg_q, s_zero_q;
  logic [4:0]  j_q;
  logic [16:0] scale_mag_q;
  logic        scale_take_q;
  logic        t_neg_q, t_zero_q;
  logic        out_valid_q;
  logic [31:0] out_value_q;
  logic [4:0]  out_pos_q;
  logic        out_last_q;

  logic        in_acc, out_free;
  logic [5:0]  ls;
  logic [4:0]  h_exp;
  logic [9:0]  h_man;
  logic [4:0]  e_eff;
  logic [10:0] d_mag;
  logic [7:0]  cur_byte;
  logic [3:0]  nib;
  logic [127:0] lvl_all;
  logic [7:0]  level;
  logic [7:0]  t_abs;
  logic        mul_load;
  logic [iq4dq_pkg::MulAW-1:0] mul_a;
  logic [iq4dq_pkg::MulBW-1:0] mul_b;
  logic [iq4dq_pkg::MulPW-1:0] prod;
  logic        v_sign;
  logic [31:0] v_word;

  assign in_stall_o = (state_q != iq4dq_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // sub-scale of the current sub-block
  assign ls = {sub_hi_q[2*cnt_q +: 2], sub_lo_q[4*cnt_q +: 4]};

  // half-precision scale decode
  assign h_exp = scale_h_q[14:10];
  assign h_man = scale_h_q[9:0];
  assign e_eff = (h_exp == 5'd0) ? 5'd1 : h_exp;
  assign d_mag = {(h_exp != 5'd0), h_man};

  // nibble and level of the current value
  assign cur_byte = bytes_q[8*j_q[3:0] +: 8];
  assign nib      = j_q[4] ? cur_byte[7:4] : cur_byte[3:0];
  assign lvl_all  = {lvl_second_q, lvl_first_q};
  assign level    = lvl_all[8*nib +: 8];
  assign t_abs    = level[7] ? 8'(-level) : level;

  // shared multiplier: scale setup then one product per value
  always_comb begin
    mul_load = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    if (state_q == iq4dq_pkg::ST_PREP) begin
      mul_load = 1'b1;
      mul_a    = iq4dq_pkg::MulAW'(d_mag);
      mul_b    = iq4dq_pkg::MulBW'(s_abs_q);
    end else if (state_q == iq4dq_pkg::ST_HOLD) begin
      mul_load = 1'b1;
      mul_a    = scale_take_q ? prod[iq4dq_pkg::MulAW-1:0] : scale_mag_q;
      mul_b    = t_abs;
    end
  end

  iq4dq_mul u_mul (
    .clk_i  (clk_i),
    .load_i (mul_load),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // result word, with infinity and nan cases
  assign v_sign = scale_h_q[15] ^ s_neg_q ^ t_neg_q;
  always_comb begin
    if (h_exp == 5'h1f) begin
      if (h_man != '0) begin
        v_word = {scale_h_q[15], 8'hff, h_man, 13'b0} | iq4dq_pkg::QuietBit;
      end else if (s_zero_q || t_zero_q) begin
        v_word = iq4dq_pkg::SingleQNan;
      end else begin
        v_word = {v_sign, 31'b0} | iq4dq_pkg::SingleInf;
      end
    end else begin
      v_word = iq4dq_pkg::to_single(v_sign, e_eff, prod[23:0]);
    end
  end

  // sequencer: idle, scale product, then per value multiply and emit
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      iq4dq_pkg::ST_IDLE: begin
        if (in_acc && opcode_i == iq4dq_pkg::OpQuant) state_d = iq4dq_pkg::ST_PREP;
      end
      iq4dq_pkg::ST_PREP: state_d = iq4dq_pkg::ST_HOLD;
      iq4dq_pkg::ST_HOLD: state_d = iq4dq_pkg::ST_VAL;
      iq4dq_pkg::ST_VAL: begin
        if (out_free) begin
          state_d = (j_q == 5'd31) ? iq4dq_pkg::ST_IDLE : iq4dq_pkg::ST_HOLD;
        end
      end
      default: state_d = iq4dq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iq4dq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration, header and counter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_first_q  <= '0;
      lvl_second_q <= '0;
      scale_h_q    <= '0;
      sub_hi_q     <= '0;
      sub_lo_q     <= '0;
      cnt_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          iq4dq_pkg::CfgLevelFirst:  lvl_first_q  <= cfg_data_i;
          iq4dq_pkg::CfgLevelSecond: lvl_second_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        if (opcode_i == iq4dq_pkg::OpHeader) begin
          scale_h_q <= block_scale_i;
          sub_hi_q  <= subscale_high_bits_i;
          sub_lo_q  <= subscale_low_nibbles_i;
          cnt_q     <= '0;
        end else if (32'(cnt_q) + 32'd1 >= 32'(Subblocks)) begin
          cnt_q <= '0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  // per item and per value working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q <= '0;
    end else begin
      if (in_acc) j_q <= '0;
      else if (state_q == iq4dq_pkg::ST_VAL && out_free) j_q <= j_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && opcode_i == iq4dq_pkg::OpQuant) begin
      bytes_q  <= {quant_bytes_second_i, quant_bytes_first_i};
      s_abs_q  <= ls[5] ? {1'b0, ls[4:0]} : 6'(6'd32 - ls);
      s_neg_q  <= !ls[5];
      s_zero_q <= (ls == 6'd32);
    end
    if (state_q == iq4dq_pkg::ST_HOLD) begin
      t_neg_q  <= level[7];
      t_zero_q <= (level == '0);
    end
  end

  // the scale product is ready in the cycle after the setup multiply
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_take_q <= 1'b0;
    end else begin
      scale_take_q <= (state_q == iq4dq_pkg::ST_PREP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (scale_take_q) scale_mag_q <= prod[iq4dq_pkg::MulAW-1:0];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == iq4dq_pkg::ST_VAL && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == iq4dq_pkg::ST_VAL && out_free) begin
      out_value_q <= v_word;
      out_pos_q   <= j_q;
      out_last_q  <= (j_q == 5'd31);
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign position_o  = out_pos_q;
  assign last_o      = out_last_q;

`ifndef SYNTHESIS
  a_quant_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && opcode_i == iq4dq_pkg::OpQuant |=> state_q == iq4dq_pkg::ST_PREP)
    else $error("quant word did not start the sequencer");
  a_header_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && opcode_i == iq4dq_pkg::OpHeader |=> cnt_q == '0)
    else $error("header did not restart the sub-block count");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) < 32'(Subblocks))
    else $error("sub-block count out of range");
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> position_o == 5'd31)
    else $error("last flag away from final position");
`endif

endmodule
